### sv/jps_pkg.sv
`default_nettype none

package jps_pkg;

  localparam int unsigned IN_W   = 32;
  localparam int unsigned OUT_W  = 56;
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 23;
  localparam int unsigned PC_W   = 4;

  // Register indexes of the configuration port.
  localparam logic [CFG_AW-1:0] REG_KP   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_KD   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_TLIM = 3'd2;
  localparam logic [CFG_AW-1:0] REG_INVM = 3'd3;
  localparam logic [CFG_AW-1:0] REG_ALO  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_AHI  = 3'd5;

  localparam logic [15:0] KP_RESET   = 16'd256;
  localparam logic [15:0] KD_RESET   = 16'd0;
  localparam logic [22:0] TLIM_RESET = 23'h7FFFFF;
  localparam logic [15:0] INVM_RESET = 16'd256;
  localparam logic [15:0] ALO_RESET  = 16'h8000;
  localparam logic [15:0] AHI_RESET  = 16'h7FFF;

  // Velocity damping factor 0.85 in Q0.16.
  localparam logic [17:0] DAMP_Q16 = 18'd55706;

  // Multiplier operand selects.
  localparam logic [2:0] M_NONE     = 3'd0;
  localparam logic [2:0] M_KP_ERR   = 3'd1;
  localparam logic [2:0] M_KD_VEL   = 3'd2;
  localparam logic [2:0] M_TQ_IM    = 3'd3;
  localparam logic [2:0] M_PHI_DT   = 3'd4;
  localparam logic [2:0] M_PLO_DT   = 3'd5;
  localparam logic [2:0] M_SUM_DAMP = 3'd6;
  localparam logic [2:0] M_VEL_DT   = 3'd7;

  // Accumulator and write-back operations.
  localparam logic [3:0] A_NONE   = 4'd0;
  localparam logic [3:0] A_LOAD   = 4'd1;
  localparam logic [3:0] A_SUBTQ  = 4'd2;
  localparam logic [3:0] A_LOADP  = 4'd3;
  localparam logic [3:0] A_LOADSH = 4'd4;
  localparam logic [3:0] A_ADD    = 4'd5;
  localparam logic [3:0] A_SUMV   = 4'd6;
  localparam logic [3:0] A_VSAT   = 4'd7;
  localparam logic [3:0] A_ANG    = 4'd8;

  // Sequencer jump conditions.
  localparam logic [1:0] J_NEXT     = 2'd0;
  localparam logic [1:0] J_WAIT_IN  = 2'd1;
  localparam logic [1:0] J_WAIT_OUT = 2'd2;

  localparam logic [PC_W-1:0] LAST_STEP = 4'd14;

  typedef struct packed {
    logic [2:0] mul_sel;
    logic [3:0] acc_op;
  } dp_ctrl_t;

  typedef struct packed {
    dp_ctrl_t   dp;
    logic [1:0] jmp;
  } ucode_t;

  typedef struct packed {
    logic [15:0] kp;
    logic [15:0] kd;
    logic [22:0] tlim;
    logic [15:0] invm;
    logic [15:0] alo;
    logic [15:0] ahi;
  } cfg_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{dp: '{mul_sel: M_NONE, acc_op: A_NONE}, jmp: J_NEXT};
    case (pc)
      4'd0:  w.jmp = J_WAIT_IN;
      4'd1:  w.dp.mul_sel = M_KP_ERR;
      4'd2:  w.dp = '{mul_sel: M_KD_VEL, acc_op: A_LOAD};
      4'd3:  w.dp.acc_op = A_SUBTQ;
      4'd4:  w.dp.mul_sel = M_TQ_IM;
      4'd5:  w.dp.acc_op = A_LOADP;
      4'd6:  w.dp.mul_sel = M_PHI_DT;
      4'd7:  w.dp = '{mul_sel: M_PLO_DT, acc_op: A_LOADSH};
      4'd8:  w.dp.acc_op = A_ADD;
      4'd9:  w.dp.acc_op = A_SUMV;
      4'd10: w.dp.mul_sel = M_SUM_DAMP;
      4'd11: w.dp.acc_op = A_VSAT;
      4'd12: w.dp.mul_sel = M_VEL_DT;
      4'd13: w.dp.acc_op = A_ANG;
      4'd14: w.jmp = J_WAIT_OUT;
      default: w.jmp = J_NEXT;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### sv/jps_datapath.sv
`default_nettype none

module jps_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire jps_pkg::dp_ctrl_t ctrl,
  input  wire jps_pkg::cfg_t     cfg,
  input  wire logic              in_load,
  input  wire logic [15:0]       target_in,
  input  wire logic [15:0]       dt_in,
  output logic [23:0]            torque,
  output logic [15:0]            angle,
  output logic [15:0]            velocity
);
  import jps_pkg::*;

  logic signed [15:0] target_r;
  logic        [15:0] dt_r;
  logic signed [15:0] angle_r, angle_nxt;
  logic signed [15:0] vel_r, vel_nxt;
  logic signed [23:0] torque_r, torque_nxt;
  logic signed [39:0] p_r;
  logic signed [57:0] acc_r, acc_nxt;
  logic signed [42:0] prod_r;

  logic signed [24:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [16:0] err;

  logic signed [33:0] diff;
  logic signed [25:0] raw, lim_p, lim_n;
  logic signed [33:0] q;
  logic signed [34:0] sum;
  logic signed [26:0] vs;
  logic signed [16:0] dang;
  logic signed [17:0] a18, ahi18, alo18;

  assign err = $signed({target_r[15], target_r}) - $signed({angle_r[15], angle_r});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.mul_sel)
      M_KP_ERR: begin
        mul_a = $signed({9'd0, cfg.kp});
        mul_b = $signed({err[16], err});
      end
      M_KD_VEL: begin
        mul_a = $signed({9'd0, cfg.kd});
        mul_b = $signed({{2{vel_r[15]}}, vel_r});
      end
      M_TQ_IM: begin
        mul_a = $signed({torque_r[23], torque_r});
        mul_b = $signed({2'd0, cfg.invm});
      end
      M_PHI_DT: begin
        mul_a = $signed({p_r[39], p_r[39:16]});
        mul_b = $signed({2'd0, dt_r});
      end
      M_PLO_DT: begin
        mul_a = $signed({9'd0, p_r[15:0]});
        mul_b = $signed({2'd0, dt_r});
      end
      M_SUM_DAMP: begin
        mul_a = $signed({{7{acc_r[17]}}, acc_r[17:0]});
        mul_b = $signed(DAMP_Q16);
      end
      M_VEL_DT: begin
        mul_a = $signed({{9{vel_r[15]}}, vel_r});
        mul_b = $signed({2'd0, dt_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    // PD sum fits in 34 bits; arithmetic shifts round toward minus infinity.
    diff  = $signed(acc_r[33:0]) - $signed(prod_r[33:0]);
    raw   = 26'(diff >>> 8);
    lim_p = $signed({3'd0, cfg.tlim});
    lim_n = -lim_p;
    q     = $signed(acc_r[57:24]);
    sum   = $signed({{19{vel_r[15]}}, vel_r}) + $signed({q[33], q});
    vs    = $signed(prod_r[42:16]);
    dang  = $signed(prod_r[32:16]);
    a18   = $signed({{2{angle_r[15]}}, angle_r}) + $signed({dang[16], dang});
    ahi18 = $signed({{2{cfg.ahi[15]}}, cfg.ahi});
    alo18 = $signed({{2{cfg.alo[15]}}, cfg.alo});

    acc_nxt    = acc_r;
    torque_nxt = torque_r;
    vel_nxt    = vel_r;
    angle_nxt  = angle_r;
    case (ctrl.acc_op)
      A_LOAD:   acc_nxt = 58'(prod_r);
      A_SUBTQ: begin
        if (raw > lim_p) begin
          torque_nxt = lim_p[23:0];
        end else if (raw < lim_n) begin
          torque_nxt = lim_n[23:0];
        end else begin
          torque_nxt = raw[23:0];
        end
      end
      A_LOADSH: acc_nxt = 58'(prod_r) <<< 16;
      A_ADD:    acc_nxt = acc_r + 58'(prod_r);
      A_SUMV: begin
        // Anything beyond 18 bits saturates the damped velocity anyway.
        if (sum > 35'sd131071) begin
          acc_nxt = 58'sd131071;
        end else if (sum < -35'sd131072) begin
          acc_nxt = -58'sd131072;
        end else begin
          acc_nxt = 58'(sum);
        end
      end
      A_VSAT: begin
        if (vs > 27'sd32767) begin
          vel_nxt = 16'sh7FFF;
        end else if (vs < -27'sd32768) begin
          vel_nxt = 16'sh8000;
        end else begin
          vel_nxt = vs[15:0];
        end
      end
      A_ANG: begin
        // Upper limit first, so crossed limits end on the lower one.
        if (a18 > ahi18) begin
          angle_nxt = cfg.ahi;
        end else if (a18 < alo18) begin
          angle_nxt = cfg.alo;
        end else begin
          angle_nxt = a18[15:0];
        end
        if ((a18 > ahi18) && (ahi18 < alo18)) begin
          angle_nxt = cfg.alo;
        end
      end
      default: acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      target_r <= target_in;
      dt_r     <= dt_in;
    end
    if (ctrl.mul_sel != M_NONE) begin
      prod_r <= mul_a * mul_b;
    end
    if (ctrl.acc_op == A_LOADP) begin
      p_r <= prod_r[39:0];
    end
    acc_r    <= acc_nxt;
    torque_r <= torque_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
      vel_r   <= '0;
    end else begin
      angle_r <= angle_nxt;
      vel_r   <= vel_nxt;
    end
  end

  assign torque   = torque_r;
  assign angle    = angle_r;
  assign velocity = vel_r;

endmodule

`default_nettype wire

### sv/joint_pd_servo_top.sv
`default_nettype none

// PD position servo for one joint with a clamped torque. Each input item carries a
// target angle and a time step; each produces one result item with the applied torque,
// the new joint angle and the new angular velocity. A 15-step microprogram drives one
// shared 25x18 multiplier and an accumulator, so an item occupies the block from
// acceptance until its result is loaded into the result register, which happens only
// once the previous result has gone; the next item can be taken in the cycle after.
// Configuration writes belong to idle periods only. Joint angle and velocity reset
// to zero.

module joint_pd_servo_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [15:0] target_angle, [31:16] time_step
  input  wire logic [jps_pkg::IN_W-1:0]       in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [23:0] applied_torque, [39:24] joint_angle_out, [55:40] joint_velocity_out
  output logic [jps_pkg::OUT_W-1:0]           out_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [jps_pkg::CFG_AW-1:0]     cfg_addr,
  input  wire logic [jps_pkg::CFG_DW-1:0]     cfg_wdata
);
  import jps_pkg::*;

  logic [PC_W-1:0]  pc_r, pc_nxt;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  cfg_t             cfg_r;
  ucode_t           uc;
  logic             in_acc;
  logic             out_free;
  logic             out_load;
  logic [23:0]      torque;
  logic [15:0]      angle;
  logic [15:0]      velocity;

  assign uc        = ucode_rom(pc_r);
  assign in_tready = (uc.jmp == J_WAIT_IN);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign out_load  = (uc.jmp == J_WAIT_OUT) && out_free;

  always_comb begin
    pc_nxt = pc_r;
    case (uc.jmp)
      J_WAIT_IN:  pc_nxt = in_acc ? pc_r + 1'b1 : pc_r;
      J_WAIT_OUT: pc_nxt = out_free ? '0 : pc_r;
      default:    pc_nxt = pc_r + 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      out_valid_r <= 1'b0;
      cfg_r       <= '{kp: KP_RESET, kd: KD_RESET, tlim: TLIM_RESET,
                       invm: INVM_RESET, alo: ALO_RESET, ahi: AHI_RESET};
    end else begin
      pc_r <= pc_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_KP:   cfg_r.kp   <= cfg_wdata[15:0];
          REG_KD:   cfg_r.kd   <= cfg_wdata[15:0];
          REG_TLIM: cfg_r.tlim <= cfg_wdata[22:0];
          REG_INVM: cfg_r.invm <= cfg_wdata[15:0];
          REG_ALO:  cfg_r.alo  <= cfg_wdata[15:0];
          REG_AHI:  cfg_r.ahi  <= cfg_wdata[15:0];
          default:  cfg_r      <= cfg_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {velocity, angle, torque};
    end
  end

  jps_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (uc.dp),
    .cfg       (cfg_r),
    .in_load   (in_acc),
    .target_in (in_tdata[15:0]),
    .dt_in     (in_tdata[31:16]),
    .torque    (torque),
    .angle     (angle),
    .velocity  (velocity)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // No second item is taken while the program runs.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input accepted while an item is in progress");

  // The result register is only overwritten once its item has gone.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_tready))
    else $error("result overwritten before it was taken");

  // A new result appears only from the final program step.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(pc_r) == LAST_STEP))
    else $error("result valid raised outside the final step");

endmodule

`default_nettype wire
